// ===== sv/wast_pkg.sv =====
// Shared types, constants and the signal level mapping for the address slot tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package wast_pkg;

   localparam int TrackedEntries = 18;
   localparam int SlotWidth      = $clog2(TrackedEntries);
   localparam int CountWidth     = $clog2(TrackedEntries + 1);
   localparam int OutSlotWidth   = 5;
   localparam int AddrWidth      = 48;
   localparam int LenWidth       = 12;
   localparam int DbmWidth       = 8;
   localparam int LevelWidth     = 8;
   localparam int CounterWidth   = 32;
   localparam int DataWidth      = 32;
   localparam int PaddrWidth     = 3;
   localparam int QueueDepth     = 2;
   localparam int QueuePtrWidth  = $clog2(QueueDepth);
   localparam int QueueFillWidth = $clog2(QueueDepth + 1);

   localparam logic [LenWidth-1:0] MinLenReset = LenWidth'(22);

   localparam logic signed [DbmWidth-1:0] LevelLowDbm  = -8'sd90;
   localparam logic signed [DbmWidth-1:0] LevelHighDbm = -8'sd40;
   localparam logic [LevelWidth-1:0]      LevelMax     = 8'd255;
   // 255 * round(2^20 / 50): floor(d * 255 / 50) for d below 50
   localparam int LevelScale = 255 * 20972;
   localparam int LevelShift = 20;
   localparam int ProdWidth  = 29;

   typedef enum logic {
      CMD_FRAME = 1'b0,
      CMD_CLEAR = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      FT_MGMT = 2'd0,
      FT_CTRL = 2'd1,
      FT_DATA = 2'd2,
      FT_MISC = 2'd3
   } frame_type_type;

   typedef enum logic [PaddrWidth-1:0] {
      REG_MIN_FRAME_LENGTH = 3'd0
   } reg_addr_type;

   typedef struct packed {
      logic                   clear;
      logic [AddrWidth-1:0]   tx;
      logic [AddrWidth-1:0]   bss;
      logic [LevelWidth-1:0]  level;
   } job_type;

   function automatic logic [LevelWidth-1:0] map_level(logic signed [DbmWidth-1:0] dbm);
      logic [DbmWidth-1:0]  offset;
      logic [ProdWidth-1:0] prod;
      offset = DbmWidth'(dbm - LevelLowDbm);
      prod   = ProdWidth'(offset[5:0]) * ProdWidth'(LevelScale);
      if (dbm <= LevelLowDbm) begin
         return '0;
      end else if (dbm >= LevelHighDbm) begin
         return LevelMax;
      end else begin
         return prod[LevelShift +: LevelWidth];
      end
   endfunction

endpackage

`default_nettype wire

// ===== sv/wast_queue.sv =====
// Two-entry job queue between the frame classifier and the table engine.
// Depends on wast_pkg for the job type and queue depth.
`timescale 1ns / 1ps
`default_nettype none

module wast_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_stall,
   input  wire wast_pkg::job_type push_job,
   output logic                   head_valid,
   output wast_pkg::job_type      head_job,
   input  wire logic              head_take
);
   import wast_pkg::*;

   job_type                   entries_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]  wr_ptr_ff;
   logic [QueuePtrWidth-1:0]  rd_ptr_ff;
   logic [QueueFillWidth-1:0] fill_ff;
   logic [QueueFillWidth-1:0] fill_in;
   logic                      push;
   logic                      pop;

   assign push_stall = (fill_ff == QueueFillWidth'(QueueDepth));
   assign head_valid = (fill_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && !push_stall;
   assign pop        = head_take && head_valid;

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== sv/wast_front.sv =====
// Frame classifier: takes request beats, drops unwanted frames, maps the signal level.
// Depends on wast_pkg; feeds wast_queue.
`timescale 1ns / 1ps
`default_nettype none

module wast_front (
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_command,
   input  wire logic [1:0]                            req_frame_type,
   input  wire logic [wast_pkg::LenWidth-1:0]         req_frame_length,
   input  wire logic signed [wast_pkg::DbmWidth-1:0]  req_signal_dbm,
   input  wire logic [wast_pkg::AddrWidth-1:0]        req_transmitter_address,
   input  wire logic [wast_pkg::AddrWidth-1:0]        req_bssid_address,
   input  wire logic [wast_pkg::LenWidth-1:0]         min_frame_length,
   output logic                                       push_valid,
   input  wire logic                                  push_stall,
   output wast_pkg::job_type                          push_job
);
   import wast_pkg::*;

   logic is_clear;
   logic is_kept;

   assign req_stall = push_stall;
   assign is_clear  = (req_command == CMD_CLEAR);
   assign is_kept   = (req_frame_type == FT_DATA) && (req_frame_length >= min_frame_length);
   assign push_valid = req_valid && (is_clear || is_kept);

   always_comb begin
      push_job.clear = is_clear;
      push_job.tx    = req_transmitter_address;
      push_job.bss   = req_bssid_address;
      push_job.level = map_level(req_signal_dbm);
   end

endmodule

`default_nettype wire

// ===== sv/wast_back.sv =====
// Table engine: content-addressed lookup and FIFO-replacement insert, one address a cycle
// when not stalled. Depends on wast_pkg; drains wast_queue and drives the response beat.
`timescale 1ns / 1ps
`default_nettype none

module wast_back (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  head_valid,
   input  wire wast_pkg::job_type                     head_job,
   output logic                                       head_take,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [wast_pkg::OutSlotWidth-1:0]          rsp_first_slot,
   output logic [wast_pkg::OutSlotWidth-1:0]          rsp_second_slot,
   output logic                                       rsp_first_was_new,
   output logic                                       rsp_second_was_new,
   output logic [wast_pkg::LevelWidth-1:0]            rsp_level,
   output logic [wast_pkg::CounterWidth-1:0]          rsp_frames_accepted
);
   import wast_pkg::*;

   typedef enum logic {
      ST_FIRST,
      ST_SECOND
   } state_type;

   state_type              state_ff;
   logic [AddrWidth-1:0]   store_ff [TrackedEntries];
   logic [CountWidth-1:0]  count_ff;
   logic [SlotWidth-1:0]   oldest_ff;
   logic [CounterWidth-1:0] counter_ff;
   logic [SlotWidth-1:0]   slot1_ff;
   logic                   new1_ff;
   logic                   rsp_valid_ff;
   logic [OutSlotWidth-1:0] first_slot_ff;
   logic [OutSlotWidth-1:0] second_slot_ff;
   logic                   first_new_ff;
   logic                   second_new_ff;
   logic [LevelWidth-1:0]  level_ff;

   logic [AddrWidth-1:0]   addr;
   logic                   found;
   logic [SlotWidth-1:0]   hit_slot;
   logic                   has_room;
   logic [SlotWidth-1:0]   ins_slot;
   logic [SlotWidth-1:0]   slot;
   logic                   out_free;
   logic                   do_clear;
   logic                   do_lookup;
   logic                   do_finish;

   assign addr     = (state_ff == ST_FIRST) ? head_job.tx : head_job.bss;
   assign has_room = (count_ff < CountWidth'(TrackedEntries));
   assign ins_slot = has_room ? count_ff[SlotWidth-1:0] : oldest_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      found    = 1'b0;
      hit_slot = '0;
      for (int i = 0; i < TrackedEntries; i++) begin
         if ((CountWidth'(i) < count_ff) && (store_ff[i] == addr)) begin
            found    = 1'b1;
            hit_slot = hit_slot | SlotWidth'(i);
         end
      end
   end

   assign slot = found ? hit_slot : ins_slot;

   assign do_clear  = (state_ff == ST_FIRST) && head_valid && head_job.clear;
   assign do_finish = (state_ff == ST_SECOND) && out_free;
   assign do_lookup = ((state_ff == ST_FIRST) && head_valid && !head_job.clear) || do_finish;
   assign head_take = do_clear || do_finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FIRST;
         count_ff     <= '0;
         oldest_ff    <= '0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (do_finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (do_clear) begin
            count_ff  <= '0;
            oldest_ff <= '0;
         end
         if (do_lookup && !found) begin
            if (has_room) begin
               count_ff <= count_ff + 1'b1;
            end else begin
               oldest_ff <= (oldest_ff == SlotWidth'(TrackedEntries - 1)) ? '0
                                                                          : oldest_ff + 1'b1;
            end
         end
         unique case (state_ff)
            ST_FIRST: begin
               if (head_valid && !head_job.clear) begin
                  slot1_ff <= slot;
                  new1_ff  <= !found;
                  state_ff <= ST_SECOND;
               end
            end
            ST_SECOND: begin
               if (out_free) begin
                  first_slot_ff  <= OutSlotWidth'(slot1_ff);
                  second_slot_ff <= OutSlotWidth'(slot);
                  first_new_ff   <= new1_ff;
                  second_new_ff  <= !found;
                  level_ff       <= head_job.level;
                  counter_ff     <= counter_ff + 1'b1;
                  state_ff       <= ST_FIRST;
               end
            end
            default: begin
               state_ff <= ST_FIRST;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_lookup && !found) begin
         store_ff[ins_slot] <= addr;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_first_slot      = first_slot_ff;
   assign rsp_second_slot     = second_slot_ff;
   assign rsp_first_was_new   = first_new_ff;
   assign rsp_second_was_new  = second_new_ff;
   assign rsp_level           = level_ff;
   assign rsp_frames_accepted = counter_ff;

endmodule

`default_nettype wire

// ===== sv/wifi_address_slot_tracker_core.sv =====
// Top level of the address slot tracker: CSR port, classifier, job queue and table engine.
// Depends on wast_pkg, wast_front, wast_queue and wast_back.
`timescale 1ns / 1ps
`default_nettype none

// Tracks transmitter and BSSID addresses of sniffed data frames in an 18-entry table with
// first-in first-out replacement; each kept frame yields one response beat with both slots,
// their new flags, a 0..255 signal level and a wrapping count of kept frames. Dropped frames
// and clear commands give no beat. A kept frame passes through states ST_FIRST and ST_SECOND
// of the table engine, one lookup-and-insert per address on the single table port, so a new
// frame waits until both addresses of the last are done; a two-entry queue lets the request
// side run ahead, and the response register frees the engine once its beat is taken. Clear
// commands are handled in ST_FIRST. min_frame_length sits at byte address 0 and resets to 22.
module wifi_address_slot_tracker_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_command,
   input  wire logic [1:0]                            req_frame_type,
   input  wire logic [wast_pkg::LenWidth-1:0]         req_frame_length,
   input  wire logic signed [wast_pkg::DbmWidth-1:0]  req_signal_dbm,
   input  wire logic [wast_pkg::AddrWidth-1:0]        req_transmitter_address,
   input  wire logic [wast_pkg::AddrWidth-1:0]        req_bssid_address,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [wast_pkg::OutSlotWidth-1:0]          rsp_first_slot,
   output logic [wast_pkg::OutSlotWidth-1:0]          rsp_second_slot,
   output logic                                       rsp_first_was_new,
   output logic                                       rsp_second_was_new,
   output logic [wast_pkg::LevelWidth-1:0]            rsp_level,
   output logic [wast_pkg::CounterWidth-1:0]          rsp_frames_accepted,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [wast_pkg::PaddrWidth-1:0]       csr_paddr,
   input  wire logic [wast_pkg::DataWidth-1:0]        csr_pwdata,
   output logic [wast_pkg::DataWidth-1:0]             csr_prdata,
   output logic                                       csr_pready
);
   import wast_pkg::*;

   logic [LenWidth-1:0] min_len_ff;
   logic                reg_hit;
   logic                push_valid;
   logic                push_stall;
   job_type             push_job;
   logic                head_valid;
   job_type             head_job;
   logic                head_take;

   assign csr_pready = 1'b1;
   assign reg_hit    = (csr_paddr[PaddrWidth-1:2] == REG_MIN_FRAME_LENGTH[PaddrWidth-1:2]);
   assign csr_prdata = reg_hit ? DataWidth'(min_len_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= MinLenReset;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_hit) begin
         min_len_ff <= csr_pwdata[LenWidth-1:0];
      end
   end

   wast_front u_front (
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_command             (req_command),
      .req_frame_type          (req_frame_type),
      .req_frame_length        (req_frame_length),
      .req_signal_dbm          (req_signal_dbm),
      .req_transmitter_address (req_transmitter_address),
      .req_bssid_address       (req_bssid_address),
      .min_frame_length        (min_len_ff),
      .push_valid              (push_valid),
      .push_stall              (push_stall),
      .push_job                (push_job)
   );

   wast_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_job   (push_job),
      .head_valid (head_valid),
      .head_job   (head_job),
      .head_take  (head_take)
   );

   wast_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (head_valid),
      .head_job            (head_job),
      .head_take           (head_take),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_first_slot      (rsp_first_slot),
      .rsp_second_slot     (rsp_second_slot),
      .rsp_first_was_new   (rsp_first_was_new),
      .rsp_second_was_new  (rsp_second_was_new),
      .rsp_level           (rsp_level),
      .rsp_frames_accepted (rsp_frames_accepted)
   );

endmodule

`default_nettype wire
